@@ sv/sit_pkg.sv @@
// Shared types and constants for the segment intersection test pipeline.
// No dependencies; imported by segment_intersection_test.
package sit_pkg;

    // Register stages in front of the divider: differences, products,
    // cross products, range test, and the dividend partial products.
    localparam int unsigned SIT_FRONT_STAGES = 5;

    // Per-word flags that ride along with the divider data.
    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } sit_flags_t;

endpackage

@@ sv/segment_intersection_test.sv @@
// 2D segment/segment intersection test with a crossing point, fully pipelined.
// Depends on sit_pkg (stage count and the flag struct).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: the start and end points
//   of segments A and B in signed fixed point. Output channel (out_valid/out_ready)
//   returns one word per input: hit, and the crossing point (zero without a hit).
//   Both channels complete a transfer when valid and ready are high at a clock edge.
// Stages: five front stages form the differences, the products, the cross products,
//   the closed-range test and the dividend partial products. The quotient comes
//   from a restoring divider with an entry register and one stage per quotient
//   bit (COORD_WIDTH + 1 stages in all), then one output register.
// Throughput: one word per cycle while out_ready is high. Each stage loads whenever
//   it or any stage after it is empty or the output word is taken, so bubbles close up
//   and new words are taken while a finished result waits at the output.
// Reset: rst_n clears every valid bit asynchronously; the pipeline comes up empty
//   with in_ready high. Data registers are not reset.
// Stall: when out_ready is low, the result holds at the output and the words
//   behind it pack up; in_ready drops only once every stage is full.
module segment_intersection_test import sit_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] a_start_x,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_x,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_x,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_x,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;          // coordinate differences, signed
    localparam int PW    = 2 * W + 2;      // products and cross products, signed
    localparam int MW    = 2 * W + 1;      // magnitude of a cross product
    localparam int QN    = MW + W;         // dividend magnitude
    localparam int LO_W  = W / 2;
    localparam int HI_W  = W - LO_W;
    localparam int DIV0  = SIT_FRONT_STAGES;
    localparam int NST   = SIT_FRONT_STAGES + W + 2;

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    // A stage may load when some stage at or after it is empty, or the
    // output word is being taken.
    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_adv
            assign adv[gi] = out_ready | ~(&vld_reg[NST-1:gi]);
        end
    endgenerate

    assign vld_next = {vld_reg[NST-2:0], in_valid};
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences
    // ------------------------------------------------------------------
    logic signed [DW-1:0] s1_dax_reg, s1_day_reg, s1_dbx_reg, s1_dby_reg;
    logic signed [DW-1:0] s1_sx_reg, s1_sy_reg;
    logic [W-1:0]         s1_ax_reg, s1_ay_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_dax_reg <= DW'(a_end_x) - DW'(a_start_x);
            s1_day_reg <= DW'(a_end_y) - DW'(a_start_y);
            s1_dbx_reg <= DW'(b_end_x) - DW'(b_start_x);
            s1_dby_reg <= DW'(b_end_y) - DW'(b_start_y);
            s1_sx_reg  <= DW'(a_start_x) - DW'(b_start_x);
            s1_sy_reg  <= DW'(a_start_y) - DW'(b_start_y);
            s1_ax_reg  <= a_start_x;
            s1_ay_reg  <= a_start_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] e_dax, e_day, e_dbx, e_dby, e_sx, e_sy;
    logic signed [PW-1:0] s2_pd1_reg, s2_pd2_reg, s2_pa1_reg, s2_pa2_reg;
    logic signed [PW-1:0] s2_pb1_reg, s2_pb2_reg;
    logic signed [DW-1:0] s2_dax_reg, s2_day_reg;
    logic [W-1:0]         s2_ax_reg, s2_ay_reg;

    assign e_dax = PW'(s1_dax_reg);
    assign e_day = PW'(s1_day_reg);
    assign e_dbx = PW'(s1_dbx_reg);
    assign e_dby = PW'(s1_dby_reg);
    assign e_sx  = PW'(s1_sx_reg);
    assign e_sy  = PW'(s1_sy_reg);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_pd1_reg <= e_dby * e_dax;
            s2_pd2_reg <= e_dbx * e_day;
            s2_pa1_reg <= e_dbx * e_sy;
            s2_pa2_reg <= e_dby * e_sx;
            s2_pb1_reg <= e_dax * e_sy;
            s2_pb2_reg <= e_day * e_sx;
            s2_dax_reg <= s1_dax_reg;
            s2_day_reg <= s1_day_reg;
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: denominator and the two numerators
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s3_den_reg, s3_na_reg, s3_nb_reg;
    logic signed [DW-1:0] s3_dax_reg, s3_day_reg;
    logic [W-1:0]         s3_ax_reg, s3_ay_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_den_reg <= s2_pd1_reg - s2_pd2_reg;
            s3_na_reg  <= s2_pa1_reg - s2_pa2_reg;
            s3_nb_reg  <= s2_pb1_reg - s2_pb2_reg;
            s3_dax_reg <= s2_dax_reg;
            s3_day_reg <= s2_day_reg;
            s3_ax_reg  <= s2_ax_reg;
            s3_ay_reg  <= s2_ay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: closed-range test and magnitudes
    // ------------------------------------------------------------------
    // True when num/den lies in [0,1], with the sign of den taken into account.
    function automatic logic in_unit(input logic signed [PW-1:0] num,
                                     input logic signed [PW-1:0] den);
        logic num_le0;
        logic num_ge0;
        num_le0 = num[PW-1] || (num == '0);
        num_ge0 = !num[PW-1];
        if (den[PW-1])
            return num_le0 && (num >= den);
        else
            return num_ge0 && (num <= den);
    endfunction

    logic [PW-1:0]  den_neg, na_neg;
    logic [DW-1:0]  dax_neg, day_neg;
    sit_flags_t     s4_flags;
    sit_flags_t     s4_flags_reg;
    logic [MW-1:0]  s4_den_mag_reg, s4_na_mag_reg;
    logic [W-1:0]   s4_dax_mag_reg, s4_day_mag_reg;
    logic [W-1:0]   s4_ax_reg, s4_ay_reg;

    assign den_neg = -s3_den_reg;
    assign na_neg  = -s3_na_reg;
    assign dax_neg = -s3_dax_reg;
    assign day_neg = -s3_day_reg;

    always_comb
    begin
        s4_flags.hit   = (s3_den_reg != '0) && in_unit(s3_na_reg, s3_den_reg)
                         && in_unit(s3_nb_reg, s3_den_reg);
        s4_flags.neg_x = s3_na_reg[PW-1] ^ s3_dax_reg[DW-1] ^ s3_den_reg[PW-1];
        s4_flags.neg_y = s3_na_reg[PW-1] ^ s3_day_reg[DW-1] ^ s3_den_reg[PW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_flags_reg   <= s4_flags;
            s4_den_mag_reg <= MW'(s3_den_reg[PW-1] ? den_neg : s3_den_reg);
            s4_na_mag_reg  <= MW'(s3_na_reg[PW-1] ? na_neg : s3_na_reg);
            s4_dax_mag_reg <= W'(s3_dax_reg[DW-1] ? dax_neg : s3_dax_reg);
            s4_day_mag_reg <= W'(s3_day_reg[DW-1] ? day_neg : s3_day_reg);
            s4_ax_reg      <= s3_ax_reg;
            s4_ay_reg      <= s3_ay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: |numA| * |d| split into two narrower partial products
    // ------------------------------------------------------------------
    logic [MW+LO_W-1:0] s5_px_lo_reg, s5_py_lo_reg;
    logic [MW+HI_W-1:0] s5_px_hi_reg, s5_py_hi_reg;
    logic [MW-1:0]      s5_den_mag_reg;
    sit_flags_t         s5_flags_reg;
    logic [W-1:0]       s5_ax_reg, s5_ay_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_px_lo_reg   <= (MW+LO_W)'(s4_na_mag_reg) * (MW+LO_W)'(s4_dax_mag_reg[LO_W-1:0]);
            s5_px_hi_reg   <= (MW+HI_W)'(s4_na_mag_reg) * (MW+HI_W)'(s4_dax_mag_reg[W-1:LO_W]);
            s5_py_lo_reg   <= (MW+LO_W)'(s4_na_mag_reg) * (MW+LO_W)'(s4_day_mag_reg[LO_W-1:0]);
            s5_py_hi_reg   <= (MW+HI_W)'(s4_na_mag_reg) * (MW+HI_W)'(s4_day_mag_reg[W-1:LO_W]);
            s5_den_mag_reg <= s4_den_mag_reg;
            s5_flags_reg   <= s4_flags_reg;
            s5_ax_reg      <= s4_ax_reg;
            s5_ay_reg      <= s4_ay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: entry register plus one restoring step per quotient bit.
    // On a hit |numA| <= |den|, so the quotient is below 2^W and the upper
    // dividend bits already start below the divisor.
    // ------------------------------------------------------------------
    logic [QN-1:0] dvd_x, dvd_y;

    assign dvd_x = (QN'(s5_px_hi_reg) << LO_W) + QN'(s5_px_lo_reg);
    assign dvd_y = (QN'(s5_py_hi_reg) << LO_W) + QN'(s5_py_lo_reg);

    logic [MW-1:0]  rx_reg [0:W];
    logic [MW-1:0]  ry_reg [0:W];
    logic [W-1:0]   lx_reg [0:W];
    logic [W-1:0]   ly_reg [0:W];
    logic [W-1:0]   qx_reg [0:W];
    logic [W-1:0]   qy_reg [0:W];
    logic [MW-1:0]  d_reg  [0:W];
    sit_flags_t     flg_reg[0:W];
    logic [W-1:0]   ax_reg [0:W];
    logic [W-1:0]   ay_reg [0:W];

    always_ff @(posedge clk)
    begin
        if (adv[DIV0])
        begin
            rx_reg[0]  <= dvd_x[QN-1:W];
            ry_reg[0]  <= dvd_y[QN-1:W];
            lx_reg[0]  <= dvd_x[W-1:0];
            ly_reg[0]  <= dvd_y[W-1:0];
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            d_reg[0]   <= s5_den_mag_reg;
            flg_reg[0] <= s5_flags_reg;
            ax_reg[0]  <= s5_ax_reg;
            ay_reg[0]  <= s5_ay_reg;
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < W; gk++)
        begin : g_div
            logic [MW:0]   tx, ty, dx, dy;
            logic          ge_x, ge_y;

            assign tx   = {rx_reg[gk], lx_reg[gk][W-1]};
            assign ty   = {ry_reg[gk], ly_reg[gk][W-1]};
            assign ge_x = tx >= {1'b0, d_reg[gk]};
            assign ge_y = ty >= {1'b0, d_reg[gk]};
            assign dx   = tx - {1'b0, d_reg[gk]};
            assign dy   = ty - {1'b0, d_reg[gk]};

            always_ff @(posedge clk)
            begin
                if (adv[DIV0+gk+1])
                begin
                    rx_reg[gk+1]  <= ge_x ? dx[MW-1:0] : tx[MW-1:0];
                    ry_reg[gk+1]  <= ge_y ? dy[MW-1:0] : ty[MW-1:0];
                    lx_reg[gk+1]  <= {lx_reg[gk][W-2:0], 1'b0};
                    ly_reg[gk+1]  <= {ly_reg[gk][W-2:0], 1'b0};
                    qx_reg[gk+1]  <= {qx_reg[gk][W-2:0], ge_x};
                    qy_reg[gk+1]  <= {qy_reg[gk][W-2:0], ge_y};
                    d_reg[gk+1]   <= d_reg[gk];
                    flg_reg[gk+1] <= flg_reg[gk];
                    ax_reg[gk+1]  <= ax_reg[gk];
                    ay_reg[gk+1]  <= ay_reg[gk];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register: apply the quotient sign and add the start point.
    // ------------------------------------------------------------------
    logic [W-1:0] qx_s, qy_s;
    logic         hit_reg;
    logic [W-1:0] cross_x_reg, cross_y_reg;

    assign qx_s = flg_reg[W].neg_x ? (~qx_reg[W] + W'(1)) : qx_reg[W];
    assign qy_s = flg_reg[W].neg_y ? (~qy_reg[W] + W'(1)) : qy_reg[W];

    always_ff @(posedge clk)
    begin
        if (adv[NST-1])
        begin
            hit_reg     <= flg_reg[W].hit;
            cross_x_reg <= flg_reg[W].hit ? ax_reg[W] + qx_s : '0;
            cross_y_reg <= flg_reg[W].hit ? ay_reg[W] + qy_s : '0;
        end
    end

    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while the output stage is empty");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&vld_reg) && !out_ready) |-> !in_ready)
        else $error("input accepted into a full stalled pipeline");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
        else $error("crossing point not cleared on a miss");

    a_hit_has_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-2] && flg_reg[W].hit) |-> (d_reg[W] != '0))
        else $error("hit flagged with a zero denominator");

endmodule
